// ===== hdl/bsmt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded stack package
// Shared widths, codes and the control store of the stack sequencer.
// ----------------------------------------------------------------------------
package bsmt_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int LIMIT_RST = 32;
    localparam int LIMIT_W   = 6;
    localparam int WORD_W    = 32;
    localparam int FUNC_W    = 2;
    localparam int STAT_W    = 2;
    localparam int UPC_W     = 5;

    // Operation codes
    localparam logic [FUNC_W-1:0] FN_PUSH = 2'd0;
    localparam logic [FUNC_W-1:0] FN_POP  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_TRAV = 2'd2;
    localparam logic [FUNC_W-1:0] FN_MMIN = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] STS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STS_OVF   = 2'd1;
    localparam logic [STAT_W-1:0] STS_EMPTY = 2'd2;

    // Sequencer step addresses
    localparam logic [UPC_W-1:0] ST_IDLE       = 5'd0;
    localparam logic [UPC_W-1:0] ST_PUSH       = 5'd1;
    localparam logic [UPC_W-1:0] ST_PUSH_OK    = 5'd2;
    localparam logic [UPC_W-1:0] ST_PUSH_OVF   = 5'd3;
    localparam logic [UPC_W-1:0] ST_EMPTY      = 5'd4;
    localparam logic [UPC_W-1:0] ST_POP        = 5'd5;
    localparam logic [UPC_W-1:0] ST_POP_WAIT   = 5'd6;
    localparam logic [UPC_W-1:0] ST_POP_EMIT   = 5'd7;
    localparam logic [UPC_W-1:0] ST_TRAV       = 5'd8;
    localparam logic [UPC_W-1:0] ST_LIST_WAIT  = 5'd9;
    localparam logic [UPC_W-1:0] ST_LIST_EMIT  = 5'd10;
    localparam logic [UPC_W-1:0] ST_LIST_END   = 5'd11;
    localparam logic [UPC_W-1:0] ST_MMIN       = 5'd12;
    localparam logic [UPC_W-1:0] ST_SCAN_WAIT0 = 5'd13;
    localparam logic [UPC_W-1:0] ST_SCAN_FIRST = 5'd14;
    localparam logic [UPC_W-1:0] ST_SCAN_WAIT  = 5'd15;
    localparam logic [UPC_W-1:0] ST_SCAN_CMP   = 5'd16;
    localparam logic [UPC_W-1:0] ST_SHIFT_INIT = 5'd17;
    localparam logic [UPC_W-1:0] ST_SHIFT_WAIT = 5'd18;
    localparam logic [UPC_W-1:0] ST_SHIFT_MOVE = 5'd19;
    localparam logic [UPC_W-1:0] ST_PLACE      = 5'd20;
    localparam logic [UPC_W-1:0] ST_EMIT_MIN   = 5'd21;

    // Word source of a result
    localparam logic [1:0] WS_ZERO  = 2'd0;
    localparam logic [1:0] WS_RDATA = 2'd1;
    localparam logic [1:0] WS_MINW  = 2'd2;

    // Last-flag source of a result
    localparam logic [1:0] LS_ZERO = 2'd0;
    localparam logic [1:0] LS_ONE  = 2'd1;
    localparam logic [1:0] LS_PTR0 = 2'd2;

    // Pointer operations
    localparam logic [2:0] PO_HOLD = 3'd0;
    localparam logic [2:0] PO_TOP  = 3'd1;
    localparam logic [2:0] PO_DEC  = 3'd2;
    localparam logic [2:0] PO_INC  = 3'd3;
    localparam logic [2:0] PO_POS1 = 3'd4;

    // Count operations
    localparam logic [1:0] CO_HOLD = 2'd0;
    localparam logic [1:0] CO_INC  = 2'd1;
    localparam logic [1:0] CO_DEC  = 2'd2;

    // Minimum tracker operations
    localparam logic [1:0] MO_HOLD = 2'd0;
    localparam logic [1:0] MO_LOAD = 2'd1;
    localparam logic [1:0] MO_UPD  = 2'd2;

    // Write address and data sources
    localparam logic [1:0] WA_CNT  = 2'd0;
    localparam logic [1:0] WA_PTRM = 2'd1;
    localparam logic [1:0] WA_TOP  = 2'd2;
    localparam logic [1:0] WD_VAL   = 2'd0;
    localparam logic [1:0] WD_RDATA = 2'd1;
    localparam logic [1:0] WD_MINW  = 2'd2;

    // Next-step modes
    localparam logic [1:0] NX_SEQ  = 2'd0;
    localparam logic [1:0] NX_JMP  = 2'd1;
    localparam logic [1:0] NX_DISP = 2'd2;

    // Jump conditions
    localparam logic [2:0] CD_ALWAYS  = 3'd0;
    localparam logic [2:0] CD_FULL    = 3'd1;
    localparam logic [2:0] CD_EMPTY   = 3'd2;
    localparam logic [2:0] CD_PTR_NZ  = 3'd3;
    localparam logic [2:0] CD_PTR_Z   = 3'd4;
    localparam logic [2:0] CD_POS_TOP = 3'd5;
    localparam logic [2:0] CD_PTR_NT  = 3'd6;

    typedef struct packed {
        logic              take_in;
        logic              emit;
        logic [STAT_W-1:0] status;
        logic [1:0]        wsel;
        logic [1:0]        lsel;
        logic [2:0]        ptr_op;
        logic [1:0]        cnt_op;
        logic [1:0]        min_op;
        logic              we;
        logic [1:0]        wa_sel;
        logic [1:0]        wd_sel;
        logic [1:0]        nxt;
        logic [2:0]        cond;
        logic [UPC_W-1:0]  target;
    } t_ctrl;

    // Control store: one control word per step.
    function automatic t_ctrl f_ucode(input logic [UPC_W-1:0] step);
        t_ctrl c;
        c = '0;
        unique case (step)
            ST_IDLE: begin
                c.take_in = 1'b1;
                c.nxt     = NX_DISP;
            end
            ST_PUSH: begin
                c.nxt    = NX_JMP;
                c.cond   = CD_FULL;
                c.target = ST_PUSH_OVF;
            end
            ST_PUSH_OK: begin
                c.we     = 1'b1;
                c.wa_sel = WA_CNT;
                c.wd_sel = WD_VAL;
                c.cnt_op = CO_INC;
                c.emit   = 1'b1;
                c.status = STS_OK;
                c.wsel   = WS_ZERO;
                c.lsel   = LS_ONE;
                c.nxt    = NX_JMP;
                c.target = ST_IDLE;
            end
            ST_PUSH_OVF: begin
                c.emit   = 1'b1;
                c.status = STS_OVF;
                c.lsel   = LS_ONE;
                c.nxt    = NX_JMP;
                c.target = ST_IDLE;
            end
            ST_EMPTY: begin
                c.emit   = 1'b1;
                c.status = STS_EMPTY;
                c.lsel   = LS_ONE;
                c.nxt    = NX_JMP;
                c.target = ST_IDLE;
            end
            ST_POP: begin
                c.ptr_op = PO_TOP;
                c.nxt    = NX_JMP;
                c.cond   = CD_EMPTY;
                c.target = ST_EMPTY;
            end
            ST_POP_WAIT: begin
                c.cnt_op = CO_DEC;
            end
            ST_POP_EMIT: begin
                c.emit   = 1'b1;
                c.wsel   = WS_RDATA;
                c.lsel   = LS_ONE;
                c.nxt    = NX_JMP;
                c.target = ST_IDLE;
            end
            ST_TRAV: begin
                c.ptr_op = PO_TOP;
                c.nxt    = NX_JMP;
                c.cond   = CD_EMPTY;
                c.target = ST_EMPTY;
            end
            ST_LIST_WAIT: begin
                c = '0;
            end
            ST_LIST_EMIT: begin
                c.emit   = 1'b1;
                c.wsel   = WS_RDATA;
                c.lsel   = LS_PTR0;
                c.ptr_op = PO_DEC;
                c.nxt    = NX_JMP;
                c.cond   = CD_PTR_NZ;
                c.target = ST_LIST_WAIT;
            end
            ST_LIST_END: begin
                c.nxt    = NX_JMP;
                c.target = ST_IDLE;
            end
            ST_MMIN: begin
                c.ptr_op = PO_TOP;
                c.nxt    = NX_JMP;
                c.cond   = CD_EMPTY;
                c.target = ST_EMPTY;
            end
            ST_SCAN_WAIT0: begin
                c = '0;
            end
            ST_SCAN_FIRST: begin
                c.min_op = MO_LOAD;
                c.ptr_op = PO_DEC;
                c.nxt    = NX_JMP;
                c.cond   = CD_PTR_Z;
                c.target = ST_PLACE;
            end
            ST_SCAN_WAIT: begin
                c = '0;
            end
            ST_SCAN_CMP: begin
                c.min_op = MO_UPD;
                c.ptr_op = PO_DEC;
                c.nxt    = NX_JMP;
                c.cond   = CD_PTR_NZ;
                c.target = ST_SCAN_WAIT;
            end
            ST_SHIFT_INIT: begin
                c.ptr_op = PO_POS1;
                c.nxt    = NX_JMP;
                c.cond   = CD_POS_TOP;
                c.target = ST_PLACE;
            end
            ST_SHIFT_WAIT: begin
                c = '0;
            end
            ST_SHIFT_MOVE: begin
                c.we     = 1'b1;
                c.wa_sel = WA_PTRM;
                c.wd_sel = WD_RDATA;
                c.ptr_op = PO_INC;
                c.nxt    = NX_JMP;
                c.cond   = CD_PTR_NT;
                c.target = ST_SHIFT_WAIT;
            end
            ST_PLACE: begin
                c.we     = 1'b1;
                c.wa_sel = WA_TOP;
                c.wd_sel = WD_MINW;
            end
            ST_EMIT_MIN: begin
                c.emit   = 1'b1;
                c.wsel   = WS_MINW;
                c.lsel   = LS_ZERO;
                c.ptr_op = PO_TOP;
                c.nxt    = NX_JMP;
                c.target = ST_LIST_WAIT;
            end
            default: begin
                c.nxt    = NX_JMP;
                c.target = ST_IDLE;
            end
        endcase
        return c;
    endfunction

    // First step of each operation.
    function automatic logic [UPC_W-1:0] f_dispatch(input logic [FUNC_W-1:0] func);
        logic [UPC_W-1:0] s;
        unique case (func)
            FN_PUSH: s = ST_PUSH;
            FN_POP:  s = ST_POP;
            FN_TRAV: s = ST_TRAV;
            FN_MMIN: s = ST_MMIN;
            default: s = ST_IDLE;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/bounded_stack_min_to_top_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded stack with move-minimum-to-top
// Signed word stack driven by a small microprogram over a dual-port RAM.
// ----------------------------------------------------------------------------
// Operations arrive on the slave stream: tuser carries the operation, tdata
// the word to push. Results leave on the master stream with the status in
// tuser, the word in tdata and tlast on the final result of an operation.
// The stack limit is written through the APB port at address 0; a write
// whose low six bits exceed DEPTH saturates to DEPTH.
// One operation is in progress at a time; the next is taken once the
// sequencer returns to its idle step. The RAM's registered read sets the
// pace: every element read passes through a wait step before its word is
// used. A move-minimum scans for the minimum, shifts the entries above it
// down, writes it on top and then gives the full listing.
// The result register lets the sequencer prepare the next result while one
// waits; when the receiver holds tready low the sequencer stalls on its next
// result step, and nothing is lost.
// Reset empties the stack and sets the limit to 32, or to DEPTH if smaller.
// The RAM contents are not cleared; only written entries are ever read.
// ----------------------------------------------------------------------------
module bounded_stack_min_to_top_core
    import bsmt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Operation stream
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [WORD_W-1:0] s_axis_tdata,   // [31:0] push_value
    input  wire logic [FUNC_W-1:0] s_axis_tuser,   // [1:0] func
    // Result stream
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic      [WORD_W-1:0] m_axis_tdata,   // [31:0] word_out
    output logic      [STAT_W-1:0] m_axis_tuser,   // [1:0] status
    output logic                   m_axis_tlast,
    // Register port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX = LIMIT_W'(DEPTH);
    localparam logic [LIMIT_W-1:0] LIMIT_INIT =
        (DEPTH < LIMIT_RST) ? LIMIT_W'(DEPTH) : LIMIT_W'(LIMIT_RST);

    logic [UPC_W-1:0]   r_upc, n_upc;
    logic [CW-1:0]      r_cnt;
    logic [AW-1:0]      r_ptr;
    logic [AW-1:0]      r_minpos;
    logic [WORD_W-1:0]  r_minw;
    logic [WORD_W-1:0]  r_val;
    logic [LIMIT_W-1:0] r_limit;
    logic               r_out_valid;
    logic [STAT_W-1:0]  r_out_status;
    logic [WORD_W-1:0]  r_out_word;
    logic               r_out_last;

    t_ctrl              w_c;
    logic               w_stall, w_go, w_cond;
    logic [CW-1:0]      w_cnt_m1;
    logic [AW-1:0]      w_top;
    logic [WORD_W-1:0]  w_rdata;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [WORD_W-1:0]  w_wdata;
    logic [WORD_W-1:0]  w_word;
    logic               w_last;
    logic               w_cfg_wr;
    logic [LIMIT_W-1:0] w_wr_limit;

    assign w_c      = f_ucode(r_upc);
    assign w_cnt_m1 = r_cnt - CW'(1);
    assign w_top    = w_cnt_m1[AW-1:0];

    // A step waits for an input transfer or for room in the result register.
    assign w_stall = (w_c.take_in & ~s_axis_tvalid)
                   | (w_c.emit & r_out_valid & ~m_axis_tready);
    assign w_go    = ~w_stall;

    assign s_axis_tready = w_c.take_in;

    always_comb begin
        case (w_c.cond)
            CD_ALWAYS:  w_cond = 1'b1;
            CD_FULL:    w_cond = (LIMIT_W'(r_cnt) >= r_limit) || (r_cnt >= CW'(DEPTH));
            CD_EMPTY:   w_cond = (r_cnt == '0);
            CD_PTR_NZ:  w_cond = (r_ptr != '0);
            CD_PTR_Z:   w_cond = (r_ptr == '0);
            CD_POS_TOP: w_cond = (r_minpos == w_top);
            CD_PTR_NT:  w_cond = (r_ptr != w_top);
            default:    w_cond = 1'b0;
        endcase
    end

    always_comb begin
        case (w_c.nxt)
            NX_SEQ:  n_upc = r_upc + UPC_W'(1);
            NX_JMP:  n_upc = w_cond ? w_c.target : r_upc + UPC_W'(1);
            NX_DISP: n_upc = f_dispatch(s_axis_tuser);
            default: n_upc = ST_IDLE;
        endcase
    end

    always_comb begin
        case (w_c.wa_sel)
            WA_CNT:  w_waddr = r_cnt[AW-1:0];
            WA_PTRM: w_waddr = r_ptr - AW'(1);
            default: w_waddr = w_top;
        endcase
        case (w_c.wd_sel)
            WD_VAL:   w_wdata = r_val;
            WD_RDATA: w_wdata = w_rdata;
            default:  w_wdata = r_minw;
        endcase
        case (w_c.wsel)
            WS_RDATA: w_word = w_rdata;
            WS_MINW:  w_word = r_minw;
            default:  w_word = '0;
        endcase
        case (w_c.lsel)
            LS_ONE:  w_last = 1'b1;
            LS_PTR0: w_last = (r_ptr == '0);
            default: w_last = 1'b0;
        endcase
    end

    assign w_we = w_c.we & w_go;

    bsmt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_ptr),
        .o_rdata (w_rdata)
    );

    // Sequencer and datapath control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= ST_IDLE;
            r_cnt <= '0;
        end else if (w_go) begin
            r_upc <= n_upc;
            case (w_c.cnt_op)
                CO_INC:  r_cnt <= r_cnt + CW'(1);
                CO_DEC:  r_cnt <= w_cnt_m1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Pointer, minimum tracker and operand registers
    always_ff @(posedge i_clk) begin
        if (w_go) begin
            case (w_c.ptr_op)
                PO_TOP:  r_ptr <= w_top;
                PO_DEC:  r_ptr <= r_ptr - AW'(1);
                PO_INC:  r_ptr <= r_ptr + AW'(1);
                PO_POS1: r_ptr <= r_minpos + AW'(1);
                default: r_ptr <= r_ptr;
            endcase
            case (w_c.min_op)
                MO_LOAD: begin
                    r_minw   <= w_rdata;
                    r_minpos <= r_ptr;
                end
                MO_UPD: begin
                    // Strictly smaller only, so ties keep the entry nearest the top.
                    if ($signed(w_rdata) < $signed(r_minw)) begin
                        r_minw   <= w_rdata;
                        r_minpos <= r_ptr;
                    end
                end
                default: begin
                    r_minw   <= r_minw;
                    r_minpos <= r_minpos;
                end
            endcase
            if (w_c.take_in) begin
                r_val <= s_axis_tdata;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_c.emit && w_go) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_c.emit && w_go) begin
            r_out_status <= w_c.status;
            r_out_word   <= w_word;
            r_out_last   <= w_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_word;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;

    // Register port
    assign pready     = 1'b1;
    assign w_cfg_wr   = psel & penable & pwrite & ~paddr[2];
    assign w_wr_limit = (pwdata[LIMIT_W-1:0] > LIMIT_MAX) ? LIMIT_MAX
                                                          : pwdata[LIMIT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_INIT;
        end else if (w_cfg_wr) begin
            r_limit <= w_wr_limit;
        end
    end

    assign prdata = paddr[2] ? 32'd0 : {{(32 - LIMIT_W){1'b0}}, r_limit};

endmodule
`default_nettype wire

// ===== hdl/bsmt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with a registered read.
// ----------------------------------------------------------------------------
module bsmt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire
